FILE: rtl/core/pllm_pkg.sv
package pllm_pkg;

  localparam int POOL_NODES = 64;
  localparam int LIST_COUNT = 4;

  localparam int NODE_W   = $clog2(POOL_NODES);
  localparam int LIST_W   = $clog2(LIST_COUNT);
  localparam int CNT_W    = $clog2(POOL_NODES + 1);
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [LIST_W-1:0]   list_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // One entry of the link memory: the next node and whether a next exists.
  typedef struct packed {
    logic  present;
    node_t link;
  } link_t;

  localparam action_t A_CLEAR  = 3'd0;
  localparam action_t A_INIT   = 3'd1;
  localparam action_t A_POP    = 3'd2;
  localparam action_t A_PUSH   = 3'd3;
  localparam action_t A_REMOVE = 3'd4;
  localparam action_t A_MOVE   = 3'd5;
  localparam action_t A_HEAD   = 3'd6;
  localparam action_t A_NEXT   = 3'd7;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;

endpackage

FILE: rtl/core/pooled_linked_list_manager_core.sv
// Linked list manager over a shared node pool. A command is taken when start_i is high and
// busy_o is low; exactly one result follows, shown for one cycle with done_o high, and the
// receiver cannot hold it off. All next links live in one single-port-write memory with a
// registered read, so each command waits on its accesses to it: clear and head go from
// decode straight to the result; pop, push, move all and next add a memory state (S_POP,
// S_PUSH, S_MOVE, S_NEXT) unless pop finds the list empty, push finds it full or move all
// changes nothing; init writes one link per node (node count capped at the pool size), and
// remove walks the list until it finds the node or reaches the end, since the walk follows
// one link per cycle. busy_o stays high until the result cycle ends.
module pooled_linked_list_manager_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pllm_pkg::action_t   action_i,
  input  pllm_pkg::list_t     list_id_i,
  input  pllm_pkg::list_t     other_list_i,
  input  pllm_pkg::node_t     node_i,
  input  pllm_pkg::cnt_t      node_count_i,
  output logic                done_o,
  output pllm_pkg::node_t     node_out_o,
  output logic                node_valid_o,
  output pllm_pkg::status_t   status_o,
  output pllm_pkg::cnt_t      list_size_o
);
  import pllm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_INIT   = 4'd2;
  localparam logic [3:0] S_POP    = 4'd3;
  localparam logic [3:0] S_PUSH   = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_REMFIN = 4'd6;
  localparam logic [3:0] S_MOVE   = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0] state_q, state_d;

  node_t head_q [LIST_COUNT];
  node_t tail_q [LIST_COUNT];
  cnt_t  cnt_q  [LIST_COUNT];

  link_t link_mem [POOL_NODES];
  link_t rd_q;
  logic  mem_we;
  node_t mem_wa;
  link_t mem_wd;
  node_t mem_ra;

  action_t act_q;
  list_t   li_q;
  list_t   src_q;
  node_t   node_q;
  cnt_t    nc_q;

  node_t   idx_q;
  node_t   prev_q;
  node_t   i_q;
  logic    first_q;
  node_t   mtail_q;
  node_t   res_node_q;
  logic    res_valid_q;
  status_t res_status_q;

  cnt_t                cnt_li;
  cnt_t                cnt_src;
  cnt_t                init_n;
  node_t               init_last;
  logic                cnt_full;
  logic [CNT_W:0]      move_sum;
  logic                move_act;
  logic                move_go;
  node_t               cur_w;
  logic                match;
  logic                at_last;

  assign cnt_li    = cnt_q[li_q];
  assign cnt_src   = cnt_q[src_q];
  assign init_n    = (nc_q > CNT_W'(POOL_NODES)) ? CNT_W'(POOL_NODES) : nc_q;
  assign init_last = NODE_W'(init_n - CNT_W'(1));
  assign cnt_full  = (cnt_li >= CNT_W'(POOL_NODES));
  assign move_sum  = {1'b0, cnt_li} + {1'b0, cnt_src};
  assign move_act  = (src_q != li_q) && (cnt_src != '0);
  assign move_go   = move_act && (move_sum <= (CNT_W + 1)'(POOL_NODES));

  // The walk takes the list head on its first step and the link just read after that,
  // so the memory is addressed with the current node every cycle.
  assign cur_w   = first_q ? head_q[li_q] : rd_q.link;
  assign match   = (cur_w == node_q);
  assign at_last = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_li);

  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = node_q;
    mem_wd  = '0;
    mem_ra  = node_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_q)
          A_CLEAR, A_HEAD: begin
            state_d = S_RESP;
          end
          A_INIT: begin
            state_d = (init_n == '0) ? S_RESP : S_INIT;
          end
          A_POP: begin
            mem_ra  = head_q[li_q];
            state_d = (cnt_li == '0) ? S_RESP : S_POP;
          end
          A_PUSH: begin
            if (cnt_full) begin
              state_d = S_RESP;
            end else begin
              if (cnt_li != '0) begin
                mem_we = 1'b1;
                mem_wa = tail_q[li_q];
                mem_wd = '{present: 1'b1, link: node_q};
              end
              state_d = S_PUSH;
            end
          end
          A_REMOVE: begin
            state_d = (cnt_li == '0) ? S_RESP : S_WALK;
          end
          A_MOVE: begin
            if (move_go) begin
              if (cnt_li != '0) begin
                mem_we = 1'b1;
                mem_wa = tail_q[li_q];
                mem_wd = '{present: 1'b1, link: head_q[src_q]};
              end
              state_d = S_MOVE;
            end else begin
              state_d = S_RESP;
            end
          end
          A_NEXT: begin
            mem_ra  = node_q;
            state_d = S_NEXT;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = idx_q;
        if (idx_q == init_last) begin
          mem_wd  = '0;
          state_d = S_RESP;
        end else begin
          mem_wd = '{present: 1'b1, link: idx_q + NODE_W'(1)};
        end
      end
      S_POP: begin
        mem_we  = 1'b1;
        mem_wa  = head_q[li_q];
        mem_wd  = '0;
        state_d = S_RESP;
      end
      S_PUSH: begin
        mem_we  = 1'b1;
        mem_wa  = node_q;
        mem_wd  = '0;
        state_d = S_RESP;
      end
      S_WALK: begin
        mem_ra = cur_w;
        if (match) begin
          if (cnt_li == CNT_W'(1)) begin
            state_d = S_RESP;
          end else if (at_last) begin
            mem_we  = 1'b1;
            mem_wa  = prev_q;
            mem_wd  = '0;
            state_d = S_RESP;
          end else begin
            state_d = S_REMFIN;
          end
        end else if (at_last) begin
          state_d = S_RESP;
        end
      end
      S_REMFIN: begin
        if (i_q != '0) begin
          mem_we = 1'b1;
          mem_wa = prev_q;
          mem_wd = '{present: 1'b1, link: rd_q.link};
        end
        state_d = S_RESP;
      end
      S_MOVE: begin
        mem_we  = 1'b1;
        mem_wa  = mtail_q;
        mem_wd  = '0;
        state_d = S_RESP;
      end
      S_NEXT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_q <= link_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int k = 0; k < LIST_COUNT; k++) begin
        head_q[k] <= '0;
        tail_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_EXEC: begin
          case (act_q)
            A_CLEAR: begin
              head_q[li_q] <= '0;
              tail_q[li_q] <= '0;
              cnt_q[li_q]  <= '0;
            end
            A_INIT: begin
              head_q[li_q] <= '0;
              tail_q[li_q] <= (init_n == '0) ? '0 : init_last;
              cnt_q[li_q]  <= init_n;
            end
            A_PUSH: begin
              if (!cnt_full) begin
                if (cnt_li == '0) begin
                  head_q[li_q] <= node_q;
                end
                tail_q[li_q] <= node_q;
                cnt_q[li_q]  <= cnt_li + CNT_W'(1);
              end
            end
            A_MOVE: begin
              if (move_go) begin
                if (cnt_li == '0) begin
                  head_q[li_q] <= head_q[src_q];
                end
                tail_q[li_q]  <= tail_q[src_q];
                cnt_q[li_q]   <= CNT_W'(move_sum);
                head_q[src_q] <= '0;
                tail_q[src_q] <= '0;
                cnt_q[src_q]  <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          if (cnt_li > CNT_W'(1)) begin
            head_q[li_q] <= rd_q.link;
          end else begin
            head_q[li_q] <= '0;
            tail_q[li_q] <= '0;
          end
          cnt_q[li_q] <= cnt_li - CNT_W'(1);
        end
        S_WALK: begin
          if (match) begin
            cnt_q[li_q] <= cnt_li - CNT_W'(1);
            if (cnt_li == CNT_W'(1)) begin
              head_q[li_q] <= '0;
              tail_q[li_q] <= '0;
            end else if (at_last) begin
              tail_q[li_q] <= prev_q;
            end
          end
        end
        S_REMFIN: begin
          if (i_q == '0) begin
            head_q[li_q] <= rd_q.link;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_q  <= action_i;
          li_q   <= list_id_i;
          src_q  <= other_list_i;
          node_q <= node_i;
          nc_q   <= node_count_i;
        end
      end
      S_EXEC: begin
        res_node_q   <= '0;
        res_valid_q  <= 1'b0;
        res_status_q <= ST_OK;
        idx_q        <= '0;
        prev_q       <= '0;
        i_q          <= '0;
        first_q      <= 1'b1;
        mtail_q      <= tail_q[src_q];
        case (act_q)
          A_POP: begin
            if (cnt_li == '0) begin
              res_status_q <= ST_EMPTY;
            end
          end
          A_PUSH: begin
            if (cnt_full) begin
              res_status_q <= ST_NOTFOUND;
            end
          end
          A_REMOVE: begin
            res_status_q <= ST_NOTFOUND;
          end
          A_MOVE: begin
            if (move_act && !move_go) begin
              res_status_q <= ST_NOTFOUND;
            end
          end
          A_HEAD: begin
            if (cnt_li == '0) begin
              res_status_q <= ST_EMPTY;
            end else begin
              res_node_q  <= head_q[li_q];
              res_valid_q <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_INIT: begin
        idx_q <= idx_q + NODE_W'(1);
      end
      S_POP: begin
        res_node_q  <= head_q[li_q];
        res_valid_q <= 1'b1;
      end
      S_WALK: begin
        if (match) begin
          res_status_q <= ST_OK;
        end else begin
          prev_q  <= cur_w;
          i_q     <= i_q + NODE_W'(1);
          first_q <= 1'b0;
        end
      end
      S_NEXT: begin
        if (rd_q.present) begin
          res_node_q  <= rd_q.link;
          res_valid_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = (state_q == S_RESP);
  assign node_out_o   = res_node_q;
  assign node_valid_o = res_valid_q;
  assign status_o     = res_status_q;
  assign list_size_o  = cnt_li;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result strobe not followed by idle");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && node_valid_o |-> status_o == ST_OK)
    else $error("node reported with a failing status");

  a_no_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !node_valid_o |-> node_out_o == '0)
    else $error("node output not zero without a node");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> list_size_o <= CNT_W'(POOL_NODES))
    else $error("list size beyond the pool");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  import pllm_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 217;

  typedef struct packed {
    node_t   node;
    logic    valid;
    status_t status;
    cnt_t    size;
  } pool_result_t;

  // Tracks the lists and the link memory as the block should hold them, and keeps the
  // results still owed by the block in transaction order.
  class list_pool_tracker;
    node_t        link_to [POOL_NODES];
    bit           link_on [POOL_NODES];
    node_t        head_of [LIST_COUNT];
    node_t        tail_of [LIST_COUNT];
    int           size_of [LIST_COUNT];
    pool_result_t awaited [$];
    int           errors;

    function new();
      foreach (link_to[i]) begin
        link_to[i] = '0;
        link_on[i] = 1'b0;
      end
      foreach (head_of[i]) begin
        head_of[i] = '0;
        tail_of[i] = '0;
        size_of[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_link(node_t from, node_t to, bit on);
      link_to[from] = to;
      link_on[from] = on;
    endfunction

    function node_t node_at(list_t li, int pos);
      node_t cur;
      cur = head_of[li];
      repeat (pos) cur = link_to[cur];
      return cur;
    endfunction

    function bit holds(node_t nd);
      bit hit;
      hit = 1'b0;
      foreach (head_of[l]) begin
        for (int k = 0; k < size_of[l]; k++) begin
          if (node_at(list_t'(l), k) == nd) hit = 1'b1;
        end
      end
      return hit;
    endfunction

    function void note_command(action_t act, list_t li, list_t src, node_t nd, cnt_t req);
      pool_result_t r;
      int           n;
      int           k;
      node_t        h;
      node_t        cur;
      node_t        prev;
      bit           hit;
      r = '0;
      r.status = ST_OK;
      prev = '0;
      hit = 1'b0;
      case (act)
        A_CLEAR: begin
          head_of[li] = '0;
          tail_of[li] = '0;
          size_of[li] = 0;
        end
        A_INIT: begin
          n = (req > POOL_NODES) ? POOL_NODES : int'(req);
          head_of[li] = '0;
          tail_of[li] = '0;
          size_of[li] = n;
          if (n > 0) begin
            for (k = 1; k < n; k++) set_link(node_t'(k - 1), node_t'(k), 1'b1);
            set_link(node_t'(n - 1), '0, 1'b0);
            tail_of[li] = node_t'(n - 1);
          end
        end
        A_POP: begin
          if (size_of[li] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            h = head_of[li];
            if (size_of[li] > 1) begin
              head_of[li] = link_to[h];
            end else begin
              head_of[li] = '0;
              tail_of[li] = '0;
            end
            set_link(h, '0, 1'b0);
            size_of[li]--;
            r.node = h;
            r.valid = 1'b1;
          end
        end
        A_PUSH: begin
          if (size_of[li] >= POOL_NODES) begin
            r.status = ST_NOTFOUND;
          end else begin
            if (size_of[li] > 0) set_link(tail_of[li], nd, 1'b1);
            else head_of[li] = nd;
            tail_of[li] = nd;
            set_link(nd, '0, 1'b0);
            size_of[li]++;
          end
        end
        A_REMOVE: begin
          r.status = ST_NOTFOUND;
          n = size_of[li];
          cur = head_of[li];
          for (k = 0; k < n && !hit; k++) begin
            if (cur == nd) begin
              if (n == 1) begin
                head_of[li] = '0;
                tail_of[li] = '0;
              end else if (k == n - 1) begin
                set_link(prev, '0, 1'b0);
                tail_of[li] = prev;
              end else if (k == 0) begin
                head_of[li] = link_to[cur];
              end else begin
                set_link(prev, link_to[cur], 1'b1);
              end
              size_of[li]--;
              r.status = ST_OK;
              hit = 1'b1;
            end else begin
              prev = cur;
              cur = link_to[cur];
            end
          end
        end
        A_MOVE: begin
          // Moving a list onto itself or moving an empty list is a no-op.
          if (src != li && size_of[src] > 0) begin
            if (size_of[li] + size_of[src] > POOL_NODES) begin
              r.status = ST_NOTFOUND;
            end else begin
              if (size_of[li] > 0) set_link(tail_of[li], head_of[src], 1'b1);
              else head_of[li] = head_of[src];
              tail_of[li] = tail_of[src];
              set_link(tail_of[src], '0, 1'b0);
              size_of[li] += size_of[src];
              head_of[src] = '0;
              tail_of[src] = '0;
              size_of[src] = 0;
            end
          end
        end
        A_HEAD: begin
          if (size_of[li] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.node = head_of[li];
            r.valid = 1'b1;
          end
        end
        A_NEXT: begin
          if (link_on[nd]) begin
            r.node = link_to[nd];
            r.valid = 1'b1;
          end
        end
        default: ;
      endcase
      r.size = cnt_t'(size_of[li]);
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, node %0d valid %0b status %0d size %0d",
                 $time, got.node, got.valid, got.status, got.size);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("node_out", 8'(want.node), 8'(got.node));
      compare_field("node_valid", 8'(want.valid), 8'(got.valid));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("list_size", 8'(want.size), 8'(got.size));
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  action_t action_i = A_CLEAR;
  list_t   list_id_i = '0;
  list_t   other_list_i = '0;
  node_t   node_i = '0;
  cnt_t    node_count_i = '0;
  logic    busy_o;
  logic    done_o;
  node_t   node_out_o;
  logic    node_valid_o;
  status_t status_o;
  cnt_t    list_size_o;

  list_pool_tracker pool_tracker = new();
  int               idle_pct = 0;
  int               cycle_count = 0;

  pooled_linked_list_manager_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .list_id_i    (list_id_i),
    .other_list_i (other_list_i),
    .node_i       (node_i),
    .node_count_i (node_count_i),
    .done_o       (done_o),
    .node_out_o   (node_out_o),
    .node_valid_o (node_valid_o),
    .status_o     (status_o),
    .list_size_o  (list_size_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      pool_tracker.check_result({node_out_o, node_valid_o, status_o, list_size_o});
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction was taken,
  // with start_i still high.
  task automatic issue_command(action_t act, list_t li, list_t src, node_t nd, cnt_t req);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    list_id_i <= li;
    other_list_i <= src;
    node_i <= nd;
    node_count_i <= req;
    do @(posedge clk_i); while (busy_o);
    pool_tracker.note_command(act, li, src, nd, req);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pool_tracker.awaited.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_command();
    int      pick;
    int      k;
    action_t act;
    list_t   li;
    list_t   src;
    node_t   nd;
    cnt_t    req;
    pick = $urandom_range(0, 99);
    li = list_t'($urandom_range(0, LIST_COUNT - 1));
    src = list_t'($urandom_range(0, LIST_COUNT - 1));
    nd = node_t'($urandom_range(0, POOL_NODES - 1));
    req = cnt_t'($urandom_range(0, 127));
    if (pick < 26) act = A_PUSH;
    else if (pick < 40) act = A_POP;
    else if (pick < 60) act = A_REMOVE;
    else if (pick < 68) act = A_MOVE;
    else if (pick < 76) act = A_HEAD;
    else if (pick < 87) act = A_NEXT;
    else if (pick < 95) act = A_INIT;
    else act = A_CLEAR;
    case (act)
      A_PUSH: begin
        // Mostly push nodes that no list holds yet, so the lists stay disjoint.
        for (k = 0; k < 4 && pool_tracker.holds(nd); k++) begin
          nd = node_t'($urandom_range(0, POOL_NODES - 1));
        end
      end
      A_REMOVE, A_NEXT: begin
        if (pool_tracker.size_of[li] > 0 && $urandom_range(0, 3) != 0) begin
          nd = pool_tracker.node_at(li, $urandom_range(0, pool_tracker.size_of[li] - 1));
        end
      end
      A_INIT: begin
        case ($urandom_range(0, 9))
          0: req = '0;
          1: req = cnt_t'($urandom_range(POOL_NODES, 127));
          2: req = cnt_t'(POOL_NODES);
          default: req = cnt_t'($urandom_range(1, 12));
        endcase
      end
      default: ;
    endcase
    issue_command(act, li, src, nd, req);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 12;
    // Empty lists straight out of reset; no link read is used before the full init below.
    issue_command(A_HEAD, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_POP, 2'd1, 2'd0, 6'd0, 7'd0);
    issue_command(A_MOVE, 2'd2, 2'd3, 6'd0, 7'd0);
    issue_command(A_INIT, 2'd0, 2'd0, 6'd0, 7'd64);
    issue_command(A_NEXT, 2'd0, 2'd0, 6'd63, 7'd0);
    issue_command(A_NEXT, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_HEAD, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_INIT, 2'd1, 2'd0, 6'd0, 7'd0);
    issue_command(A_INIT, 2'd1, 2'd0, 6'd0, 7'd127);
    issue_command(A_PUSH, 2'd1, 2'd0, 6'd5, 7'd0);
    issue_command(A_MOVE, 2'd0, 2'd1, 6'd0, 7'd0);
    issue_command(A_CLEAR, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_MOVE, 2'd0, 2'd1, 6'd0, 7'd0);
    issue_command(A_MOVE, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_POP, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_REMOVE, 2'd0, 2'd0, 6'd63, 7'd0);
    issue_command(A_REMOVE, 2'd0, 2'd0, 6'd1, 7'd0);
    issue_command(A_REMOVE, 2'd0, 2'd0, 6'd30, 7'd0);
    issue_command(A_REMOVE, 2'd0, 2'd0, 6'd30, 7'd0);
    issue_command(A_REMOVE, 2'd2, 2'd0, 6'd0, 7'd0);
    issue_command(A_PUSH, 2'd3, 2'd0, 6'd42, 7'd0);
    issue_command(A_REMOVE, 2'd3, 2'd0, 6'd42, 7'd0);
    issue_command(A_NEXT, 2'd0, 2'd0, 6'd0, 7'd0);
    issue_command(A_CLEAR, 2'd0, 2'd0, 6'd0, 7'd0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 64 : 0;
      repeat (ITEMS_PER_PHASE) random_command();
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pool_tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
